// File: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and fixed constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // fixed field widths
   localparam int SIZE_W   = 16;
   localparam int LIMIT_W  = 17;
   localparam int STATUS_W = 2;

   // smallest data area worth splitting off
   localparam int SPLIT_MIN_DATA = 8;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OUT_OF_MEM = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_NONE    = 3'd0,
      CELL_SETFREE = 3'd1,
      CELL_INSERT  = 3'd2,
      CELL_REMOVE  = 3'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        wr_free;
      logic        mode_free;
   } cell_cmd_type;

endpackage

// File: rtl/ffha_cell.sv
// ----------------------------------------------------------------------------
// ffha_cell
// One table entry: header offset and free flag, with shift to and from its
// neighbors and a local fit / match check.
// ----------------------------------------------------------------------------
module ffha_cell #(
   parameter int IDX          = 0,
   parameter int AW           = 19,
   parameter int CW           = 7,
   parameter int IW           = 6,
   parameter int HEADER_BYTES = 16
) (
   input  logic                 clock,
   input  ffha_pkg::cell_cmd_type cmd,
   input  logic [IW-1:0]        pos,
   input  logic [AW-1:0]        wr_start,
   input  logic [AW-1:0]        left_start,
   input  logic                 left_free,
   input  logic [AW-1:0]        right_start,
   input  logic                 right_free,
   input  logic [CW-1:0]        count,
   input  logic [AW-1:0]        break_offset,
   input  logic [AW-1:0]        asz,
   input  logic [AW-1:0]        foff,
   output logic [AW-1:0]        start,
   output logic                 free,
   output logic                 hit,
   output logic                 split
);
   import ffha_pkg::*;

   localparam logic [IW-1:0] MY_POS  = IW'(IDX);
   localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);
   localparam logic [AW-1:0] HDR     = AW'(HEADER_BYTES);
   localparam logic [AW-1:0] SPLIT_X = AW'(HEADER_BYTES + SPLIT_MIN_DATA);

   logic [AW-1:0] start_ff, start_in;
   logic          free_ff, free_in;
   logic [AW-1:0] data_beg, blk_end, dsize;

   // entry update from command
   always_comb begin
      start_in = start_ff;
      free_in  = free_ff;
      case (cmd.op)
         CELL_SETFREE: begin
            if (pos == MY_POS) free_in = cmd.wr_free;
         end
         CELL_INSERT: begin
            if (pos == MY_POS) begin
               start_in = wr_start;
               free_in  = cmd.wr_free;
            end else if (MY_POS > pos) begin
               start_in = left_start;
               free_in  = left_free;
            end
         end
         CELL_REMOVE: begin
            if (MY_POS >= pos) begin
               start_in = right_start;
               free_in  = right_free;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      free_ff  <= free_in;
   end

   // data size of this block and local checks
   always_comb begin
      data_beg = start_ff + HDR;
      blk_end  = (count == MY_NEXT) ? break_offset : right_start;
      dsize    = (blk_end > data_beg) ? blk_end - data_beg : '0;
      split    = dsize >= asz + SPLIT_X;
      hit      = cmd.mode_free ? (data_beg == foff) : (free_ff && dsize >= asz);
   end

   assign start = start_ff;
   assign free  = free_ff;

endmodule

// File: rtl/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator over a chain of table cells, with split on
// allocate and neighbor merge on free.
// ----------------------------------------------------------------------------
// Sequence: scans the table entry by entry up to the block count, then updates
//   the table (take, split, append, or mark and merge) and presents the result.
// Requests: one at a time; a new request is taken only after the response
//   has been accepted, so receiver stalls also hold the unit.
// Reset: synchronous; clears block count, break, limit to 65536 and the
//   control state. Table cells are not cleared; only entries below the count
//   are ever read. ALIGN_BYTES must be a power of two.
module first_fit_heap_allocator_unit #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 16,
   parameter int ALIGN_BYTES  = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [ffha_pkg::SIZE_W-1:0]    req_request_size,
   input  logic [ffha_pkg::SIZE_W-1:0]    req_free_offset,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ffha_pkg::SIZE_W-1:0]    rsp_data_offset,
   output logic [ffha_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                           csr_write_enable,
   input  logic [ffha_pkg::LIMIT_W-1:0]   csr_write_data
);
   import ffha_pkg::*;

   localparam int HB_W = ($clog2(HEAP_BYTES) > SIZE_W) ? $clog2(HEAP_BYTES) : SIZE_W + 1;
   localparam int AW   = HB_W + 2;
   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam int IW   = $clog2(MAX_BLOCKS);
   localparam logic [AW-1:0] HDR    = AW'(HEADER_BYTES);
   localparam logic [AW-1:0] AMASK  = AW'(ALIGN_BYTES - 1);
   localparam logic [AW-1:0] HEAP_L = AW'(HEAP_BYTES);
   localparam logic [CW-1:0] MAXC   = CW'(MAX_BLOCKS);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_SCAN    = 10'b0000000010,
      S_TAKE    = 10'b0000000100,
      S_SPLIT   = 10'b0000001000,
      S_APPEND  = 10'b0000010000,
      S_MARK    = 10'b0000100000,
      S_MERGE_L = 10'b0001000000,
      S_MERGE_R = 10'b0010000000,
      S_TRIM    = 10'b0100000000,
      S_RESP    = 10'b1000000000
   } state_type;

   function automatic logic [AW-1:0] round_up(input logic [AW-1:0] v);
      round_up = (v + AMASK) & ~AMASK;
   endfunction

   state_type            state_ff, state_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        brk_ff, brk_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 mode_ff, mode_in;
   logic [AW-1:0]        asz_ff, asz_in;
   logic [AW-1:0]        foff_ff, foff_in;
   logic [AW-1:0]        off_ff, off_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   cell_cmd_type         cmd;
   logic [IW-1:0]        cmd_pos;
   logic [AW-1:0]        cmd_start;

   logic [AW-1:0]        c_start [MAX_BLOCKS];
   logic                 c_free  [MAX_BLOCKS];
   logic                 c_hit   [MAX_BLOCKS];
   logic                 c_split [MAX_BLOCKS];

   logic [IW-1:0]        idx_p;
   logic [IW-1:0]        idx_m1;
   logic [IW-1:0]        idx_p1;
   logic [AW-1:0]        app_start, app_end, lim_eff;

   // chain of table cells
   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      logic [AW-1:0] ls, rs;
      logic          lf, rf;
      if (k == 0) begin : g_l0
         assign ls = '0;
         assign lf = 1'b0;
      end else begin : g_ln
         assign ls = c_start[k-1];
         assign lf = c_free[k-1];
      end
      if (k == MAX_BLOCKS - 1) begin : g_rl
         assign rs = '0;
         assign rf = 1'b0;
      end else begin : g_rn
         assign rs = c_start[k+1];
         assign rf = c_free[k+1];
      end
      ffha_cell #(
         .IDX(k), .AW(AW), .CW(CW), .IW(IW), .HEADER_BYTES(HEADER_BYTES)
      ) u_cell (
         .clock(clock), .cmd(cmd), .pos(cmd_pos), .wr_start(cmd_start),
         .left_start(ls), .left_free(lf), .right_start(rs), .right_free(rf),
         .count(count_ff), .break_offset(brk_ff), .asz(asz_ff), .foff(foff_ff),
         .start(c_start[k]), .free(c_free[k]), .hit(c_hit[k]), .split(c_split[k])
      );
   end

   // index helpers
   assign idx_p  = idx_ff[IW-1:0];
   assign idx_m1 = idx_p - IW'(1);
   assign idx_p1 = idx_p + IW'(1);

   // append geometry and effective limit
   always_comb begin
      app_start = round_up(brk_ff);
      app_end   = app_start + HDR + asz_ff;
      lim_eff   = (AW'(limit_ff) < HEAP_L) ? AW'(limit_ff) : HEAP_L;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      limit_in     = csr_write_enable ? csr_write_data : limit_ff;
      count_in     = count_ff;
      brk_in       = brk_ff;
      idx_in       = idx_ff;
      mode_in      = mode_ff;
      asz_in       = asz_ff;
      foff_in      = foff_ff;
      off_in       = off_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '{op: CELL_NONE, wr_free: 1'b0, mode_free: mode_ff};
      cmd_pos      = idx_p;
      cmd_start    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               asz_in   = round_up(AW'(req_request_size));
               foff_in  = AW'(req_free_offset);
               idx_in   = '0;
               off_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == count_ff) begin
               if (mode_ff) begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_APPEND;
               end
            end else if (c_hit[idx_p]) begin
               state_in = mode_ff ? S_MARK : S_TAKE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_TAKE: begin
            cmd.op     = CELL_SETFREE;
            cmd.wr_free = 1'b0;
            off_in     = c_start[idx_p] + HDR;
            status_in  = STATUS_OK;
            state_in   = (c_split[idx_p] && count_ff < MAXC) ? S_SPLIT : S_RESP;
         end
         S_SPLIT: begin
            cmd.op      = CELL_INSERT;
            cmd.wr_free = 1'b1;
            cmd_pos     = idx_p1;
            cmd_start   = off_ff + asz_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_RESP;
         end
         S_APPEND: begin
            if (count_ff >= MAXC || app_end > lim_eff) begin
               status_in = STATUS_OUT_OF_MEM;
            end else begin
               cmd.op      = CELL_INSERT;
               cmd.wr_free = 1'b0;
               cmd_pos     = count_ff[IW-1:0];
               cmd_start   = app_start;
               count_in    = count_ff + CW'(1);
               brk_in      = app_end;
               off_in      = app_start + HDR;
               status_in   = STATUS_OK;
            end
            state_in = S_RESP;
         end
         S_MARK: begin
            cmd.op      = CELL_SETFREE;
            cmd.wr_free = 1'b1;
            state_in    = S_MERGE_L;
         end
         S_MERGE_L: begin
            if (idx_ff != '0 && c_free[idx_m1]) begin
               cmd.op   = CELL_REMOVE;
               count_in = count_ff - CW'(1);
               idx_in   = idx_ff - CW'(1);
            end
            state_in = S_MERGE_R;
         end
         S_MERGE_R: begin
            if (idx_ff + CW'(1) < count_ff && c_free[idx_p1]) begin
               cmd.op   = CELL_REMOVE;
               cmd_pos  = idx_p1;
               count_in = count_ff - CW'(1);
            end
            state_in = S_TRIM;
         end
         S_TRIM: begin
            if (idx_ff + CW'(1) == count_ff) begin
               brk_in   = c_start[idx_p];
               count_in = count_ff - CW'(1);
            end
            status_in = STATUS_OK;
            state_in  = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_W'(65536);
         count_ff     <= '0;
         brk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         brk_ff       <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      mode_ff   <= mode_in;
      asz_ff    <= asz_in;
      foff_ff   <= foff_in;
      off_ff    <= off_in;
      status_ff <= status_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_offset = (status_ff == STATUS_OK) ? off_ff[SIZE_W-1:0] : '0;
   assign rsp_status      = status_ff;

   // checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAXC) else $error("block count above table size");

   a_empty_break: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> brk_ff == '0) else $error("empty heap with nonzero break");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("request taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_OUT_OF_MEM ||
                     rsp_status == STATUS_NOT_FOUND)) else $error("bad status code");

endmodule
